// ===== rtl/core/apr_pkg.sv =====
// ---------------------------------------------------------------------------
// apr_pkg
// shared types and constants of the box push-out resolver
// ---------------------------------------------------------------------------
package apr_pkg;

    localparam int MAX_BOXES_DEF   = 32;
    localparam int COORD_WIDTH_DEF = 16;

    localparam logic [2:0] CFG_BOUND_MIN_X  = 3'd0;
    localparam logic [2:0] CFG_BOUND_MAX_X  = 3'd1;
    localparam logic [2:0] CFG_BOUND_MIN_Y  = 3'd2;
    localparam logic [2:0] CFG_BOUND_MAX_Y  = 3'd3;
    localparam logic [2:0] CFG_PROBE_RADIUS = 3'd4;
    localparam logic [2:0] CFG_BOX_COUNT    = 3'd5;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_RESOLVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [4:0]         box_index;
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_max_y;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_vx;
        logic signed [15:0] new_vy;
        logic [5:0]         hit_count;
    } t_out_item;

endpackage

// ===== rtl/core/apr_cell.sv =====
// ---------------------------------------------------------------------------
// apr_cell
// one box slot of the rotating box ring
// ---------------------------------------------------------------------------
module apr_cell #(
    parameter int COORD_WIDTH = apr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_load,
    input  logic [4*COORD_WIDTH-1:0]      i_load_box,
    input  logic [4*COORD_WIDTH-1:0]      i_prev_box,
    output logic [4*COORD_WIDTH-1:0]      o_box
);
    logic [4*COORD_WIDTH-1:0] r_box;

    // load wins; otherwise rotate one step along the ring
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_load_box;
        end else if (i_shift) begin
            r_box <= i_prev_box;
        end
    end

    assign o_box = r_box;
endmodule

// ===== rtl/core/apr_push.sv =====
// ---------------------------------------------------------------------------
// apr_push
// overlap test and minimum-overlap push for one box against the probe
// ---------------------------------------------------------------------------
module apr_push #(
    parameter int COORD_WIDTH = apr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic                          i_step,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic [COORD_WIDTH-2:0]        i_radius,
    input  logic [4*COORD_WIDTH-1:0]      i_box,
    output logic signed [COORD_WIDTH-1:0] o_rx,
    output logic signed [COORD_WIDTH-1:0] o_ry,
    output logic signed [COORD_WIDTH-1:0] o_vx,
    output logic signed [COORD_WIDTH-1:0] o_vy,
    output logic [5:0]                    o_hits
);
    localparam int W = COORD_WIDTH + 3;
    localparam logic signed [W-1:0] SMAX = W'((1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [W-1:0] SMIN = -SMAX - W'(1);

    logic signed [COORD_WIDTH-1:0] r_rx, r_ry, r_vx, r_vy;
    logic [5:0] r_hits;

    logic signed [W-1:0] lx, hx, ly, hy, pxr, pxl, pyr, pyl;
    logic signed [W-1:0] ov0, ov1, ov2, ov3, sx, sy;
    logic hit;
    logic [1:0] best;

    always_comb begin
        lx  = W'($signed(i_box[4*COORD_WIDTH-1:3*COORD_WIDTH]));
        hx  = W'($signed(i_box[3*COORD_WIDTH-1:2*COORD_WIDTH]));
        ly  = W'($signed(i_box[2*COORD_WIDTH-1:COORD_WIDTH]));
        hy  = W'($signed(i_box[COORD_WIDTH-1:0]));
        pxr = W'(i_px) + W'({1'b0, i_radius});
        pxl = W'(i_px) - W'({1'b0, i_radius});
        pyr = W'(i_py) + W'({1'b0, i_radius});
        pyl = W'(i_py) - W'({1'b0, i_radius});
        hit = (pxr > lx) && (pxl < hx) && (pyr > ly) && (pyl < hy);
        ov0 = pxr - lx;
        ov1 = hx - pxl;
        ov2 = pyr - ly;
        ov3 = hy - pyl;
        best = 2'd0;
        if (ov1 < ov0) begin
            best = 2'd1;
        end
        if (ov2 < ((best == 2'd1) ? ov1 : ov0)) begin
            best = 2'd2;
        end
        case (best)
            2'd0:    sx = (ov3 < ov0) ? W'(0) : ov0;
            default: sx = W'(0);
        endcase
        // resolve winner including top
        if (ov3 < ((best == 2'd0) ? ov0 : (best == 2'd1) ? ov1 : ov2)) begin
            best = 2'd3;
        end
        sx = W'(r_rx);
        sy = W'(r_ry);
        case (best)
            2'd0:    sx = W'(r_rx) - ov0;
            2'd1:    sx = W'(r_rx) + ov1;
            2'd2:    sy = W'(r_ry) - ov2;
            default: sy = W'(r_ry) + ov3;
        endcase
        if (sx > SMAX) begin
            sx = SMAX;
        end else if (sx < SMIN) begin
            sx = SMIN;
        end
        if (sy > SMAX) begin
            sy = SMAX;
        end else if (sy < SMIN) begin
            sy = SMIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rx   <= i_px;
            r_ry   <= i_py;
            r_vx   <= i_vx;
            r_vy   <= i_vy;
            r_hits <= '0;
        end else if (i_step && hit) begin
            r_rx <= COORD_WIDTH'(sx);
            r_ry <= COORD_WIDTH'(sy);
            if (best[1]) begin
                r_vy <= '0;
            end else begin
                r_vx <= '0;
            end
            if (r_hits != 6'd63) begin
                r_hits <= r_hits + 6'd1;
            end
        end
    end

    assign o_rx   = r_rx;
    assign o_ry   = r_ry;
    assign o_vx   = r_vx;
    assign o_vy   = r_vy;
    assign o_hits = r_hits;
endmodule

// ===== rtl/core/aabb_pushout_resolver.sv =====
// ---------------------------------------------------------------------------
// aabb_pushout_resolver
// pushes a square probe out of a ring of axis-aligned boxes
// ---------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_stall  | i_in (t_in_item)
// out     | output    | o_valid / i_stall  | o_out (t_out_item)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a load transfer is taken while the block is idle. a resolve holds the input stalled
// while the box ring rotates once past the single push unit, one box per cycle;
// boxes beyond box_count are skipped but still rotate through, and the OUT state then
// hands the result to the output register. o_valid rises at that hand-off, when the
// block also returns to idle and can take the next input transfer.
// a waiting result does not block the input; only a second resolve that finishes
// while the first result still waits holds the input stalled until the out transfer.
// reset clears control and loads the register defaults; the box ring is not cleared.
// ---------------------------------------------------------------------------
module aabb_pushout_resolver #(
    parameter int MAX_BOXES   = apr_pkg::MAX_BOXES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  apr_pkg::t_in_item  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output apr_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int COORD_WIDTH = apr_pkg::COORD_WIDTH_DEF;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int BW = 4 * COORD_WIDTH;
    // width that holds both the step counter and the box count
    localparam int SW = (CW > 6) ? CW : 6;

    apr_pkg::t_state r_state, n_state;

    logic signed [15:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [14:0]        r_radius;
    logic [5:0]         r_count;
    logic [CW-1:0]      r_step, n_step;
    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_vx, r_vy;
    logic               r_out_valid;
    apr_pkg::t_out_item r_out;

    logic [BW-1:0] w_box [MAX_BOXES];
    logic          acc_in, start, shift, out_free;
    logic [BW-1:0] load_box;
    logic signed [15:0] cx, cy;
    logic signed [COORD_WIDTH-1:0] u_rx, u_ry, u_vx, u_vy;
    logic [5:0]    u_hits;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != apr_pkg::ST_IDLE);
    assign acc_in      = i_valid && !o_stall;
    assign start       = acc_in && (i_in.kind == apr_pkg::KIND_RESOLVE);
    assign shift       = (r_state == apr_pkg::ST_RUN);
    // output register is empty or is emptied at this edge
    assign out_free    = !r_out_valid || !i_stall;

    // box corners cast to the coordinate width
    assign load_box = {COORD_WIDTH'(i_in.box_min_x), COORD_WIDTH'(i_in.box_max_x),
                       COORD_WIDTH'(i_in.box_min_y), COORD_WIDTH'(i_in.box_max_y)};

    // ring of cells: cell 0 feeds the push unit, each cell takes the next, cell 0 wraps to the last
    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        apr_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
            .i_clk      (i_clk),
            .i_shift    (shift),
            .i_load     (acc_in && (i_in.kind == apr_pkg::KIND_LOAD)
                         && ({27'd0, i_in.box_index} == 32'(g))),
            .i_load_box (load_box),
            .i_prev_box (w_box[(g + 1) % MAX_BOXES]),
            .o_box      (w_box[g])
        );
    end

    // clamp, min test first; with inverted bounds a position below min gives min, any other max
    always_comb begin
        if (i_in.pos_x < r_min_x) begin
            cx = r_min_x;
        end else if (i_in.pos_x > r_max_x) begin
            cx = r_max_x;
        end else begin
            cx = i_in.pos_x;
        end
        if (i_in.pos_y < r_min_y) begin
            cy = r_min_y;
        end else if (i_in.pos_y > r_max_y) begin
            cy = r_max_y;
        end else begin
            cy = i_in.pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_px <= COORD_WIDTH'(cx);
            r_py <= COORD_WIDTH'(cy);
            r_vx <= COORD_WIDTH'(i_in.vel_x);
            r_vy <= COORD_WIDTH'(i_in.vel_y);
        end
    end

    // step s sees box s at cell 0; only steps below box_count push
    apr_push #(.COORD_WIDTH(COORD_WIDTH)) u_push (
        .i_clk    (i_clk),
        .i_start  (r_state == apr_pkg::ST_IDLE && start),
        .i_step   (shift && (SW'(r_step) < SW'(r_count))),
        .i_px     (start ? COORD_WIDTH'(cx) : r_px),
        .i_py     (start ? COORD_WIDTH'(cy) : r_py),
        .i_vx     (start ? COORD_WIDTH'(i_in.vel_x) : r_vx),
        .i_vy     (start ? COORD_WIDTH'(i_in.vel_y) : r_vy),
        .i_radius ((COORD_WIDTH-1)'(r_radius)),
        .i_box    (w_box[0]),
        .o_rx     (u_rx),
        .o_ry     (u_ry),
        .o_vx     (u_vx),
        .o_vy     (u_vy),
        .o_hits   (u_hits)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            apr_pkg::ST_IDLE: begin
                n_step = '0;
                if (start) begin
                    n_state = apr_pkg::ST_RUN;
                end
            end
            apr_pkg::ST_RUN: begin
                n_step = r_step + CW'(1);
                if (r_step == CW'(MAX_BOXES - 1)) begin
                    n_state = apr_pkg::ST_OUT;
                end
            end
            apr_pkg::ST_OUT: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    n_state = apr_pkg::ST_IDLE;
                end
            end
            default: n_state = apr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apr_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_min_x     <= -16'sd3482;
            r_max_x     <= 16'sd3891;
            r_min_y     <= -16'sd6554;
            r_max_y     <= 16'sd3277;
            r_radius    <= 15'd246;
            r_count     <= 6'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_state == apr_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    apr_pkg::CFG_BOUND_MIN_X:  r_min_x  <= i_cfg_data;
                    apr_pkg::CFG_BOUND_MAX_X:  r_max_x  <= i_cfg_data;
                    apr_pkg::CFG_BOUND_MIN_Y:  r_min_y  <= i_cfg_data;
                    apr_pkg::CFG_BOUND_MAX_Y:  r_max_y  <= i_cfg_data;
                    apr_pkg::CFG_PROBE_RADIUS: r_radius <= i_cfg_data[14:0];
                    apr_pkg::CFG_BOX_COUNT:    r_count  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // output register, loaded from the push unit at the hand-off
    always_ff @(posedge i_clk) begin
        if (r_state == apr_pkg::ST_OUT && out_free) begin
            r_out.new_x     <= 16'(u_rx);
            r_out.new_y     <= 16'(u_ry);
            r_out.new_vx    <= 16'(u_vx);
            r_out.new_vy    <= 16'(u_vy);
            r_out.hit_count <= u_hits;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;
endmodule

// ===== tb/apr_checker.sv =====
// ---------------------------------------------------------------------------
// apr_checker
// watches the box push-out resolver and scores every resolved position
// ---------------------------------------------------------------------------
module apr_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  apr_pkg::t_in_item i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  apr_pkg::t_out_item i_out,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results,
    output int                o_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import apr_pkg::*;

    localparam int NBOX = MAX_BOXES_DEF;

    longint bmin_x, bmax_x, bmin_y, bmax_y, radius;
    int     count_cfg;
    longint box_lx [NBOX];
    longint box_hx [NBOX];
    longint box_ly [NBOX];
    longint box_hy [NBOX];

    t_out_item pushout_q[$];

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_out_item resolve_probe(t_in_item it);
        longint px, py, rx, ry, vx, vy;
        longint ov [4];
        int n, best, hits;
        t_out_item res;
        px = it.pos_x;
        if (px < bmin_x) px = bmin_x;
        else if (px > bmax_x) px = bmax_x;
        py = it.pos_y;
        if (py < bmin_y) py = bmin_y;
        else if (py > bmax_y) py = bmax_y;
        px = sat16(px);
        py = sat16(py);
        rx = px;
        ry = py;
        vx = it.vel_x;
        vy = it.vel_y;
        hits = 0;
        n = (count_cfg > NBOX) ? NBOX : count_cfg;
        for (int i = 0; i < n; i++) begin
            // overlaps always against the clamped position
            if (px + radius > box_lx[i] && px - radius < box_hx[i] &&
                py + radius > box_ly[i] && py - radius < box_hy[i]) begin
                ov[0] = (px + radius) - box_lx[i];
                ov[1] = box_hx[i] - (px - radius);
                ov[2] = (py + radius) - box_ly[i];
                ov[3] = box_hy[i] - (py - radius);
                best = 0;
                for (int k = 1; k < 4; k++)
                    if (ov[k] < ov[best]) best = k;
                case (best)
                    0: begin rx = sat16(rx - ov[0]); vx = 0; end
                    1: begin rx = sat16(rx + ov[1]); vx = 0; end
                    2: begin ry = sat16(ry - ov[2]); vy = 0; end
                    default: begin ry = sat16(ry + ov[3]); vy = 0; end
                endcase
                if (hits < 63) hits++;
            end
        end
        res.new_x     = 16'(rx);
        res.new_y     = 16'(ry);
        res.new_vx    = 16'(vx);
        res.new_vy    = 16'(vy);
        res.hit_count = 6'(hits);
        return res;
    endfunction

    task automatic report_field(string name, longint exp_v, longint act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            bmin_x = -3482;
            bmax_x = 3891;
            bmin_y = -6554;
            bmax_y = 3277;
            radius = 246;
            count_cfg = 0;
            pushout_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOUND_MIN_X:  bmin_x = $signed(i_cfg_data);
                    CFG_BOUND_MAX_X:  bmax_x = $signed(i_cfg_data);
                    CFG_BOUND_MIN_Y:  bmin_y = $signed(i_cfg_data);
                    CFG_BOUND_MAX_Y:  bmax_y = $signed(i_cfg_data);
                    CFG_PROBE_RADIUS: radius = i_cfg_data[14:0];
                    CFG_BOX_COUNT:    count_cfg = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.kind == KIND_LOAD) begin
                    box_lx[i_in.box_index] = i_in.box_min_x;
                    box_hx[i_in.box_index] = i_in.box_max_x;
                    box_ly[i_in.box_index] = i_in.box_min_y;
                    box_hy[i_in.box_index] = i_in.box_max_y;
                end else begin
                    pushout_q.insert(pushout_q.size(), resolve_probe(i_in));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (pushout_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t result transfer with nothing expected", $realtime);
                end else begin
                    exp_item = pushout_q.pop_front();
                    o_hits += i_out.hit_count;
                    if (i_out.new_x !== exp_item.new_x)
                        report_field("new_x", exp_item.new_x, i_out.new_x);
                    if (i_out.new_y !== exp_item.new_y)
                        report_field("new_y", exp_item.new_y, i_out.new_y);
                    if (i_out.new_vx !== exp_item.new_vx)
                        report_field("new_vx", exp_item.new_vx, i_out.new_vx);
                    if (i_out.new_vy !== exp_item.new_vy)
                        report_field("new_vy", exp_item.new_vy, i_out.new_vy);
                    if (i_out.hit_count !== exp_item.hit_count)
                        report_field("hit_count", exp_item.hit_count, i_out.hit_count);
                end
            end
        end
        o_pending <= pushout_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_hits       = 0;
    end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the box push-out resolver
// ---------------------------------------------------------------------------
// loads every box entry first so no resolve ever sees an unwritten entry,
// then runs a directed set of pushes and a series of random phases, each
// under its own register setting and one of four idle/stall patterns; the
// checker beside the block predicts and scores every result transfer
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import apr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_PHASE = 220;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_in;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    int fail_count, pending, results, hits;
    int idle_pct, stall_pct;
    int hold_req;
    int quiet_cycles;
    int loads_sent, resolves_sent;

    aabb_pushout_resolver uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    apr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in         (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_hits       (hits)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random stall, or a long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one input transfer, with random idle cycles in front
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (o_stall);
        if (it.kind == KIND_LOAD) loads_sent++;
        else resolves_sent++;
    endtask

    // registers only change with the block idle and drained
    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(int mnx, int mxx, int mny, int mxy, int rad, int cnt);
        cfg_write(CFG_BOUND_MIN_X, 16'(mnx));
        cfg_write(CFG_BOUND_MAX_X, 16'(mxx));
        cfg_write(CFG_BOUND_MIN_Y, 16'(mny));
        cfg_write(CFG_BOUND_MAX_Y, 16'(mxy));
        cfg_write(CFG_PROBE_RADIUS, 16'(rad));
        cfg_write(CFG_BOX_COUNT, 16'(cnt));
    endtask

    function automatic t_in_item make_load(int idx, int lx, int hx, int ly, int hy);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        it.kind      = KIND_LOAD;
        it.box_index = 5'(idx);
        it.box_min_x = 16'(lx);
        it.box_max_x = 16'(hx);
        it.box_min_y = 16'(ly);
        it.box_max_y = 16'(hy);
        return it;
    endfunction

    function automatic t_in_item make_resolve(int x, int y, int vx, int vy);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        it.kind  = KIND_RESOLVE;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.vel_x = 16'(vx);
        it.vel_y = 16'(vy);
        return it;
    endfunction

    function automatic int near_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // mostly plausible boxes and positions near the play area, some raw noise
    function automatic t_in_item random_item();
        t_in_item it;
        int lx, ly;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        if ($urandom_range(99) < 25) begin
            it.kind = KIND_LOAD;
            if ($urandom_range(99) < 85) begin
                lx = near_coord(10000);
                ly = near_coord(10000);
                it.box_min_x = 16'(lx);
                it.box_max_x = 16'(lx + int'($urandom_range(6000)));
                it.box_min_y = 16'(ly);
                it.box_max_y = 16'(ly + int'($urandom_range(6000)));
            end
        end else begin
            it.kind = KIND_RESOLVE;
            if ($urandom_range(99) < 80) begin
                it.pos_x = 16'(near_coord(12000));
                it.pos_y = 16'(near_coord(12000));
            end
        end
        return it;
    endfunction

    initial begin
        int mnx, mxx, mny, mxy;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_in        = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BOUND_MIN_X;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 0;
        quiet_cycles = 0;
        loads_sent  = 0;
        resolves_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole box table before any resolve can read it
        send_item(make_load(0, -1000, 1000, -1000, 1000));
        send_item(make_load(1, -32768, 32767, -32768, 32767));
        send_item(make_load(2, 1000, -1000, 1000, -1000));   // inverted box
        for (int i = 3; i < MAX_BOXES_DEF; i++)
            send_item(($urandom_range(99) < 80) ? make_load(i, -9000 + i * 500,
                -8000 + i * 500, -2000, 2000) : make_load(i, 0, 0, 0, 0));

        // directed pushes: one box, each side, the tie and the extremes
        apply_setting(-3482, 3891, -6554, 3277, 246, 1);
        send_item(make_resolve(-1100, 0, 32767, -32768));     // push left
        send_item(make_resolve(1100, 0, -32768, 32767));      // push right
        send_item(make_resolve(0, -1100, 1234, -1234));       // push down
        send_item(make_resolve(0, 1100, -1, 1));              // push up
        send_item(make_resolve(0, 0, 100, 100));              // tie goes left
        send_item(make_resolve(-32768, 32767, 0, 0));         // clamped to corner
        send_item(make_resolve(5000, -5000, 7, 7));           // no overlap
        // full-range box and huge probe drive the sums into saturation
        apply_setting(-32768, 32767, -32768, 32767, 32767, 3);
        send_item(make_resolve(32767, -32768, 500, 500));
        send_item(make_resolve(-32768, 32767, -500, -500));
        send_item(make_resolve(0, 0, 0, 0));
        // inverted bounds, box count past the table size
        apply_setting(1000, -1000, 2000, -2000, 0, 63);
        send_item(make_resolve(0, 0, 11, 22));
        send_item(make_resolve(-5000, 5000, 33, 44));
        send_item(make_resolve(32767, -32768, 55, 66));

        // random phases, idling pattern rotates with the phase
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            mnx = -int'($urandom_range(12000));
            mxx = int'($urandom_range(12000));
            mny = -int'($urandom_range(12000));
            mxy = int'($urandom_range(12000));
            case (ph)
                1: apply_setting(mnx, mxx, mny, mxy, 0, 32);
                2: apply_setting(mnx, mxx, mny, mxy, 32767, 63);
                3: apply_setting(-32768, 32767, -32768, 32767, $urandom_range(3000), 32);
                4: apply_setting(mxx, mnx, mxy, mny, $urandom_range(3000), 20);
                5: apply_setting(mnx, mxx, mny, mxy, $urandom_range(3000), 0);
                default: apply_setting(mnx, mxx, mny, mxy, $urandom_range(3000),
                                       $urandom_range(40));
            endcase
            if (ph == 0) begin
                // receiver holds off while items keep coming; the block backs up
                hold_req = 1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
                    // sender pauses until every result is back
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    wait (pending == 0);
                end
                send_item(random_item());
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (60) @(posedge i_clk);

        $display("covered %0d box loads and %0d resolves, %0d results with %0d box hits",
                 loads_sent, resolves_sent, results, hits);
        $display("eight register settings incl. inverted bounds, zero and full probe size");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== aabb_pushout_resolver.f =====
rtl/core/apr_pkg.sv
rtl/core/apr_cell.sv
rtl/core/apr_push.sv
rtl/core/aabb_pushout_resolver.sv
tb/apr_checker.sv
tb/testbench.sv
